// ----- src/ose_pkg.sv -----
// Shared types and constants for the ordered sequence engine.
`default_nettype none
package ose_pkg;
  localparam int unsigned DepthDefault = 256;
  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned CapWidth = 9;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE         = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6,
    OP_NONE          = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  position;
    logic [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic        success;
    logic [8:0]  result_index;
    logic [31:0] read_value;
    logic [8:0]  item_count;
    logic        is_empty;
  } rsp_t;

  // Decoded command handed from the front end to the executor.
  typedef struct packed {
    op_e         op;
    logic [8:0]  position;
    logic [31:0] item_value;
  } job_t;
endpackage
`default_nettype wire

// ----- src/ose_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module ose_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ----- src/ose_front.sv -----
// Front end: accepts commands, decodes them and queues them for the executor.
`default_nettype none
module ose_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ose_pkg::cmd_t  cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  output ose_pkg::job_t       job_o,
  output logic                job_valid_o,
  input  wire logic           job_ready_i
);
  import ose_pkg::*;

  job_t       q_mem [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  job_t       dec;

  // Every 3-bit code is a member of op_e, so the code maps straight across.
  always_comb begin
    dec.position   = cmd_i.position;
    dec.item_value = cmd_i.item_value;
    dec.op         = op_e'(cmd_i.op);
  end

  assign cmd_ready_o = (cnt_q != 2'(QueueDepth));
  assign push        = cmd_valid_i && cmd_ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count did not grow on push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty queue");
endmodule
`default_nettype wire

// ----- src/ose_exec.sv -----
// Back end: carries out one list command at a time against the entry RAM.
`default_nettype none
module ose_exec #(
  parameter int unsigned Depth = ose_pkg::DepthDefault,
  parameter int unsigned ValueWidth = ose_pkg::ValueWidthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [ose_pkg::CapWidth-1:0] capacity_i,
  input  wire ose_pkg::job_t             job_i,
  input  wire logic                      job_valid_i,
  output logic                           job_ready_o,
  output ose_pkg::rsp_t                  rsp_o,
  output logic                           rsp_valid_o,
  input  wire logic                      rsp_ready_i
);
  import ose_pkg::*;

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_DATA  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e                state_q;
  job_t                  job_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         i_q;       // scan/read pointer
  logic [CW-1:0]         j_q;       // compaction write pointer
  logic [CW-1:0]         target_q;  // insert position
  logic                  found_q;
  logic [ValueWidth-1:0] carry_q;   // value travelling up during insert
  logic [ValueWidth-1:0] next_q;    // entry displaced by the carried value
  rsp_t                  rsp_q;
  logic                  rsp_valid_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [ValueWidth-1:0] ram_wdata, ram_rdata;

  ose_ram #(.Width(ValueWidth), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic [ValueWidth-1:0] val;
  logic [CW-1:0]         pos_w, limit;
  logic                  full;

  assign val = ValueWidth'(job_q.item_value);
  // A set only runs with a position below the count, so it always fits.
  assign pos_w = CW'(job_q.position);
  assign limit = (32'(capacity_i) > Depth) ? CW'(Depth) : CW'(capacity_i);
  assign full = (count_q >= limit);

  assign job_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // Single RAM port: ISSUE reads entry i; WRITE stores to the chosen slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(i_q);
    ram_wdata = carry_q;
    if (state_q == S_WRITE) begin
      ram_we = 1'b1;
      unique case (job_q.op)
        OP_SET: begin
          ram_addr  = AW'(pos_w);
          ram_wdata = val;
        end
        OP_ERASE, OP_REMOVE_ALL: begin
          ram_addr  = AW'(j_q);
          ram_wdata = carry_q;
        end
        default: begin
          ram_addr  = AW'(i_q);
          ram_wdata = carry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && job_valid_i && job_ready_o) begin
      job_q <= job_i;
    end
  end

  // Per-command sequencing. Each command walks entries one RAM access at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      target_q    <= '0;
      found_q     <= 1'b0;
      carry_q     <= '0;
      next_q      <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i && job_ready_o) begin
            state_q <= S_DONE;
            i_q     <= '0;
            j_q     <= '0;
            found_q <= 1'b0;
            rsp_q   <= '0;
            unique case (job_i.op)
              OP_INSERT_AT: begin
                if (32'(job_i.position) <= 32'(count_q) && !full) begin
                  target_q <= CW'(job_i.position);
                  i_q      <= CW'(job_i.position);
                  carry_q  <= ValueWidth'(job_i.item_value);
                  found_q  <= 1'b1;
                  state_q  <= (CW'(job_i.position) == count_q) ? S_WRITE : S_ISSUE;
                end
              end
              OP_INSERT_SORTED: begin
                carry_q <= ValueWidth'(job_i.item_value);
                if (!full) begin
                  if (count_q == '0) begin
                    target_q <= '0;
                    found_q  <= 1'b1;
                    state_q  <= S_WRITE;
                  end else begin
                    state_q <= S_ISSUE;
                  end
                end
              end
              OP_ERASE: begin
                if (32'(job_i.position) < 32'(count_q)) begin
                  j_q     <= CW'(job_i.position);
                  i_q     <= CW'(job_i.position) + CW'(1);
                  found_q <= 1'b1;
                  state_q <= S_ISSUE;
                end
              end
              OP_REMOVE_ALL, OP_FIND: begin
                state_q <= S_ISSUE;
              end
              OP_GET: begin
                if (32'(job_i.position) < 32'(count_q)) begin
                  i_q     <= CW'(job_i.position);
                  state_q <= S_ISSUE;
                end
              end
              OP_SET: begin
                if (32'(job_i.position) < 32'(count_q)) begin
                  state_q <= S_WRITE;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_ISSUE: begin
          // A scan that ran past the last entry ends here.
          if (i_q >= count_q && job_q.op != OP_INSERT_AT) begin
            state_q <= S_DONE;
            if (job_q.op == OP_INSERT_SORTED && !found_q) begin
              target_q <= count_q;
              found_q  <= 1'b1;
              i_q      <= count_q;
              state_q  <= S_WRITE;
            end else if (job_q.op == OP_INSERT_SORTED) begin
              state_q <= S_WRITE;
            end else if (job_q.op == OP_ERASE) begin
              count_q <= count_q - CW'(1);
            end else if (job_q.op == OP_REMOVE_ALL) begin
              rsp_q.success      <= (j_q != count_q);
              rsp_q.result_index <= 9'(count_q - j_q);
              count_q            <= j_q;
            end
          end else if (job_q.op == OP_INSERT_AT && i_q >= count_q) begin
            state_q <= S_WRITE;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: state_q <= S_DATA;
        S_DATA: begin
          state_q <= S_ISSUE;
          unique case (job_q.op)
            OP_GET: begin
              rsp_q.success    <= 1'b1;
              rsp_q.read_value <= 32'(ram_rdata);
              state_q          <= S_DONE;
            end
            OP_FIND: begin
              if (ram_rdata == val) begin
                rsp_q.success      <= 1'b1;
                rsp_q.result_index <= 9'(i_q);
                state_q            <= S_DONE;
              end else begin
                i_q <= i_q + CW'(1);
              end
            end
            OP_REMOVE_ALL: begin
              if (ram_rdata != val) begin
                carry_q <= ram_rdata;
                state_q <= S_WRITE;
              end
              i_q <= i_q + CW'(1);
            end
            OP_ERASE: begin
              carry_q <= ram_rdata;
              state_q <= S_WRITE;
              i_q     <= i_q + CW'(1);
            end
            default: begin
              // Sorted insert searching, or any insert shifting entries up.
              if (!found_q && val <= ram_rdata) begin
                found_q  <= 1'b1;
                target_q <= i_q;
              end
              if (found_q || val <= ram_rdata) begin
                next_q  <= ram_rdata;
                state_q <= S_WRITE;
              end else begin
                i_q <= i_q + CW'(1);
              end
            end
          endcase
        end
        S_WRITE: begin
          state_q <= S_ISSUE;
          unique case (job_q.op)
            OP_SET: begin
              rsp_q.success <= 1'b1;
              state_q       <= S_DONE;
            end
            OP_ERASE, OP_REMOVE_ALL: j_q <= j_q + CW'(1);
            default: begin
              // Store the carried value; the old entry rides up one slot.
              if (i_q == count_q) begin
                count_q            <= count_q + CW'(1);
                rsp_q.success      <= 1'b1;
                rsp_q.result_index <= 9'(target_q);
                state_q            <= S_DONE;
              end else begin
                carry_q <= next_q;
                i_q     <= i_q + CW'(1);
              end
            end
          endcase
        end
        S_DONE: begin
          if (job_q.op == OP_ERASE) rsp_q.success <= found_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          rsp_q.item_count <= 9'(count_q);
          rsp_q.is_empty   <= (count_q == '0);
          rsp_valid_q      <= 1'b1;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("entry count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_ready_i) |=> $stable(rsp_q))
    else $error("response changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> ($past(count_q) == count_q))
    else $error("count moved while idle");
endmodule
`default_nettype wire

// ----- src/ordered_sequence_engine.sv -----
// Top level of the ordered sequence engine.
`default_nettype none
// A bounded ordered list of values kept in a single-port RAM plus an entry
// count. Commands (insert at position, sorted insert, erase, remove all
// equal, get, set, find) enter through a small front-end queue, so a
// command transfer is taken while the executor works on the previous one.
// The executor handles one command at a time and touches the RAM once per
// cycle: every read passes through the issue, wait and data states (address,
// RAM latency, use) and each moved entry adds a write state. A set goes
// straight to its write, a get reads one entry, find reads entries until a
// match, and insert, erase and remove_all walk the entries up to the end of
// the list. The response is held in an output register until its transfer
// completes. Capacity is taken as min(capacity, DEPTH).
module ordered_sequence_engine #(
  parameter int unsigned DEPTH = ose_pkg::DepthDefault,
  parameter int unsigned VALUE_WIDTH = ose_pkg::ValueWidthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ose_pkg::CapWidth-1:0] cfg_wdata_i,
  input  wire ose_pkg::cmd_t                cmd_i,
  input  wire logic                         cmd_valid_i,
  output logic                              cmd_ready_o,
  output ose_pkg::rsp_t                     rsp_o,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i
);
  import ose_pkg::*;

  logic [CapWidth-1:0] capacity_q;
  job_t                job;
  logic                job_valid, job_ready;

  // Capacity register; reset allows the full 256 entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 9'd256;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  ose_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cmd_valid_i (cmd_valid_i),
    .cmd_ready_o (cmd_ready_o),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  ose_exec #(.Depth(DEPTH), .ValueWidth(VALUE_WIDTH)) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (capacity_q),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.is_empty) |-> rsp_o.item_count == 9'd0)
    else $error("empty flag disagrees with count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o)
    else $error("response dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.read_value != 32'd0) |-> rsp_o.success)
    else $error("read value without success");
endmodule
`default_nettype wire

// ----- dv/ordered_sequence_engine_tb.sv -----
// Self-checking testbench for the ordered sequence engine list processor.
module ordered_sequence_engine_tb;
  import ose_pkg::*;

  localparam int unsigned ListDepth = 256;
  localparam int unsigned RandomItems = 840;
  // Cycles with no transfer before the run is declared hung. A full-list
  // walk visits every entry, and the receiver may stall on top.
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 4 * ListDepth + 50;

  // Idle modes that set how often the sender and receiver insert gaps.
  typedef enum int {
    MODE_FLOW, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH
  } idle_mode_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CapWidth-1:0] cfg_wdata_i;
  cmd_t cmd_i;
  logic cmd_valid_i;
  logic cmd_ready_o;
  rsp_t rsp_o;
  logic rsp_valid_o;
  logic rsp_ready_i;

  ordered_sequence_engine dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i(cmd_i),
    .cmd_valid_i(cmd_valid_i),
    .cmd_ready_o(cmd_ready_o),
    .rsp_o(rsp_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the list, used to work out every response in advance.
  logic [31:0] shadow_list[ListDepth];
  int unsigned shadow_count;
  int unsigned shadow_capacity;

  rsp_t pending_rsp[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit timed_out;
  idle_mode_e idle_mode;
  bit hold_off;
  int unsigned hold_cycles;

  function automatic bit try_place(int unsigned pos, logic [31:0] val);
    int unsigned lim;
    lim = (shadow_capacity < ListDepth) ? shadow_capacity : ListDepth;
    if (pos > shadow_count || shadow_count >= lim) return 1'b0;
    for (int unsigned i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[pos] = val;
    shadow_count++;
    return 1'b1;
  endfunction

  // Applies one command to the shadow list and returns the response it
  // should produce.
  function automatic rsp_t list_apply(cmd_t c);
    rsp_t r;
    int unsigned p;
    int unsigned kept;
    r = '0;
    case (op_e'(c.op))
      OP_INSERT_AT: begin
        if (try_place(c.position, c.item_value)) begin
          r.success = 1'b1;
          r.result_index = c.position;
        end
      end
      OP_INSERT_SORTED: begin
        p = shadow_count;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (c.item_value <= shadow_list[i]) begin
            p = i;
            break;
          end
        end
        if (try_place(p, c.item_value)) begin
          r.success = 1'b1;
          r.result_index = p[8:0];
        end
      end
      OP_ERASE: begin
        if (c.position < shadow_count) begin
          for (int unsigned i = c.position; i + 1 < shadow_count; i++) begin
            shadow_list[i] = shadow_list[i + 1];
          end
          shadow_count--;
          r.success = 1'b1;
        end
      end
      OP_REMOVE_ALL: begin
        kept = 0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] != c.item_value) begin
            shadow_list[kept] = shadow_list[i];
            kept++;
          end
        end
        r.result_index = 9'(shadow_count - kept);
        r.success = (shadow_count != kept);
        shadow_count = kept;
      end
      OP_GET: begin
        if (c.position < shadow_count) begin
          r.read_value = shadow_list[c.position];
          r.success = 1'b1;
        end
      end
      OP_SET: begin
        if (c.position < shadow_count) begin
          shadow_list[c.position] = c.item_value;
          r.success = 1'b1;
        end
      end
      OP_FIND: begin
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_list[i] == c.item_value) begin
            r.success = 1'b1;
            r.result_index = i[8:0];
            break;
          end
        end
      end
      default: ;
    endcase
    r.item_count = shadow_count[8:0];
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  // Response side: compare each transfer against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected response %h", rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.success !== want.success || rsp_o.result_index !== want.result_index ||
            rsp_o.read_value !== want.read_value || rsp_o.item_count !== want.item_count ||
            rsp_o.is_empty !== want.is_empty) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Response mismatch: expected %h, got %h", want, rsp_o);
          end
        end
      end
    end
  end

  // Receiver readiness. A long hold-off lets the command queue fill and
  // back-pressure the sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_off) begin
      rsp_ready_i <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else if (idle_mode == MODE_RECV_STALL || idle_mode == MODE_BOTH) begin
      rsp_ready_i <= ($urandom_range(99) >= 77);
    end else begin
      rsp_ready_i <= 1'b1;
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_valid_i && cmd_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one command and waits for its transfer; the expectation is
  // recorded at the edge where the transfer happens. Valid stays high into
  // the next command unless the sender idles first.
  task automatic send_cmd(cmd_t c);
    if (idle_mode == MODE_SEND_IDLE || idle_mode == MODE_BOTH) begin
      if ($urandom_range(99) < 77) begin
        cmd_valid_i <= 1'b0;
        @(posedge clk_i);
        while ($urandom_range(99) < 77) @(posedge clk_i);
      end
    end
    cmd_i <= c;
    cmd_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cmd_ready_o);
    pending_rsp.push_back(list_apply(c));
  endtask

  // Stops offering, waits until every response has arrived, then lets the
  // executor settle before a register write.
  task automatic drain;
    cmd_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(int unsigned cap);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_capacity = cap;
  endtask

  function automatic cmd_t make_cmd(op_e op, int unsigned pos, logic [31:0] val);
    cmd_t c;
    c.op = op;
    c.position = pos[8:0];
    c.item_value = val;
    return c;
  endfunction

  // Random command, biased toward valid positions and a small value pool
  // so that sorted inserts, finds and remove_all hit duplicates often.
  function automatic cmd_t rand_cmd(int unsigned grow);
    cmd_t c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < grow) c.op = ($urandom_range(1)) ? OP_INSERT_AT : OP_INSERT_SORTED;
    else if (roll < 98) c.op = 3'($urandom_range(2, 6));
    else c.op = OP_NONE;
    if ($urandom_range(9) == 0) c.position = 9'($urandom);
    else c.position = 9'($urandom_range(shadow_count));
    c.item_value = ($urandom_range(2) == 0) ? $urandom : 32'($urandom_range(15));
    return c;
  endfunction

  typedef struct {
    cmd_t cmd;
    bit   typed;
    rsp_t rsp;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic stim_row_t row(cmd_t c, bit typed, rsp_t r);
    stim_row_t s;
    s.cmd = c;
    s.typed = typed;
    s.rsp = r;
    return s;
  endfunction

  initial begin
    rsp_t known;
    int unsigned caps[4];
    mismatch_count = 0;
    timed_out = 1'b0;
    hold_off = 1'b0;
    idle_mode = MODE_FLOW;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cmd_i = '0;
    cmd_valid_i = 1'b0;
    shadow_count = 0;
    shadow_capacity = 256;
    foreach (shadow_list[i]) shadow_list[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Rows with typed-in responses cover the empty list
    // after reset and the error paths; the rest use the shadow list.
    known = '0;
    known.is_empty = 1'b1;
    directed.push_back(row(make_cmd(OP_GET, 0, '0), 1'b1, known));
    directed.push_back(row(make_cmd(OP_ERASE, 511, '0), 1'b1, known));
    directed.push_back(row(make_cmd(OP_SET, 0, '1), 1'b1, known));
    directed.push_back(row(make_cmd(OP_FIND, 0, '0), 1'b1, known));
    directed.push_back(row(make_cmd(OP_REMOVE_ALL, 0, '0), 1'b1, known));
    directed.push_back(row(make_cmd(OP_NONE, 511, '1), 1'b1, known));
    directed.push_back(row(make_cmd(OP_INSERT_AT, 1, 32'h5), 1'b1, known));
    directed.push_back(row(make_cmd(OP_INSERT_AT, 0, '1), 1'b0, known));
    directed.push_back(row(make_cmd(OP_INSERT_AT, 0, '0), 1'b0, known));
    directed.push_back(row(make_cmd(OP_INSERT_SORTED, 0, 32'h7), 1'b0, known));
    directed.push_back(row(make_cmd(OP_INSERT_SORTED, 0, 32'h7), 1'b0, known));
    directed.push_back(row(make_cmd(OP_INSERT_SORTED, 0, '1), 1'b0, known));
    directed.push_back(row(make_cmd(OP_INSERT_AT, 5, 32'hAAAA5555), 1'b0, known));
    directed.push_back(row(make_cmd(OP_GET, 3, '0), 1'b0, known));
    directed.push_back(row(make_cmd(OP_GET, 4, '0), 1'b0, known));
    directed.push_back(row(make_cmd(OP_SET, 4, 32'h5555AAAA), 1'b0, known));
    directed.push_back(row(make_cmd(OP_FIND, 0, 32'h7), 1'b0, known));
    directed.push_back(row(make_cmd(OP_FIND, 0, 32'h1234), 1'b0, known));
    directed.push_back(row(make_cmd(OP_REMOVE_ALL, 0, 32'h7), 1'b0, known));
    directed.push_back(row(make_cmd(OP_ERASE, 0, '0), 1'b0, known));
    directed.push_back(row(make_cmd(OP_ERASE, 9, '0), 1'b0, known));
    directed.push_back(row(make_cmd(OP_NONE, 0, '0), 1'b0, known));
    foreach (directed[i]) begin
      send_cmd(directed[i].cmd);
      if (directed[i].typed) begin
        // The typed response replaces the predicted one for this row.
        void'(pending_rsp.pop_back());
        pending_rsp.push_back(directed[i].rsp);
      end
    end

    // Capacity of zero: every insert must fail with a non-empty list.
    write_capacity(0);
    send_cmd(make_cmd(OP_INSERT_AT, 0, 32'h1));
    send_cmd(make_cmd(OP_INSERT_SORTED, 0, 32'h1));
    // Capacity above the store depth is clamped; fill the list completely.
    write_capacity(511);
    while (shadow_count < ListDepth) begin
      send_cmd(make_cmd(OP_INSERT_SORTED, 0, $urandom));
    end
    send_cmd(make_cmd(OP_INSERT_AT, 0, 32'h1));
    send_cmd(make_cmd(OP_GET, 255, '0));
    send_cmd(make_cmd(OP_ERASE, 255, '0));
    // Capacity lowered below the count keeps the entries but blocks inserts.
    write_capacity(1);
    send_cmd(make_cmd(OP_INSERT_SORTED, 0, 32'h0));
    send_cmd(make_cmd(OP_REMOVE_ALL, 0, shadow_list[0]));

    // Random phases across capacities and idle modes. Most phases keep the
    // list short so the long walks stay rare.
    caps[0] = 8;
    caps[1] = 1;
    caps[2] = 256;
    caps[3] = 40;
    for (int ph = 0; ph < 4; ph++) begin
      write_capacity(caps[ph]);
      // Empty the list so small capacities get exercised from the bottom.
      while (shadow_count > 0) send_cmd(make_cmd(OP_ERASE, 0, '0));
      idle_mode = idle_mode_e'(ph);
      for (int n = 0; n < RandomItems / 4; n++) begin
        if (ph == 2 && n == 100) begin
          // Long receiver hold-off while the sender keeps offering.
          hold_off = 1'b1;
          fork
            begin
              while (hold_cycles < 400) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        send_cmd(rand_cmd((shadow_count < 12) ? 60 : 35));
      end
    end

    drain();
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
